### src/arw_pkg.sv
// ----------------------------------------------------------------------------
// arw_pkg
// Shared types and constants for the anti-replay window checker.
// ----------------------------------------------------------------------------
package arw_pkg;

   localparam int unsigned NONCE_BITS = 64;
   localparam logic [NONCE_BITS-1:0] LIMIT_RESET = 64'd18446744073709549630;

   typedef enum logic [1:0] {
      V_OK    = 2'd0,
      V_DUP   = 2'd1,
      V_OLD   = 2'd2,
      V_LIMIT = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_UPDATE
   } state_type;

   // result handed from the controller to the output register
   typedef struct packed {
      logic        load;
      verdict_type verdict;
   } resp_type;

endpackage

### src/arw_ring_mem.sv
// ----------------------------------------------------------------------------
// arw_ring_mem
// Simple dual-port ring memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module arw_ring_mem #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned WIDTH = 117
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/arw_ctrl.sv
// ----------------------------------------------------------------------------
// arw_ctrl
// Window check sequencer: limit and age checks, highest-seen tracking and
// read-modify-write of the ring bitmap with per-word epoch tags.
// ----------------------------------------------------------------------------
module arw_ctrl
   import arw_pkg::*;
#(
   parameter int unsigned WORD_BITS   = 64,
   parameter int unsigned RING_WORDS  = 32,
   parameter int unsigned WINDOW_SIZE = 1984,
   localparam int unsigned LW = $clog2(WORD_BITS),
   localparam int unsigned LR = $clog2(RING_WORDS),
   localparam int unsigned TAG_BITS = NONCE_BITS - LW - LR,
   localparam int unsigned MEM_BITS = WORD_BITS + TAG_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [NONCE_BITS-1:0] req_tdata,
   input  logic [NONCE_BITS-1:0] limit,
   input  logic                  out_free,
   output resp_type              resp,
   output logic                  mem_we,
   output logic [LR-1:0]         mem_waddr,
   output logic [MEM_BITS-1:0]   mem_wdata,
   output logic                  mem_re,
   output logic [LR-1:0]         mem_raddr,
   input  logic [MEM_BITS-1:0]   mem_rdata
);

   state_type state_ff, state_in;

   logic [NONCE_BITS-1:0] nonce_ff;
   logic [NONCE_BITS-1:0] n_ff;
   logic [NONCE_BITS-1:0] highest_ff;
   verdict_type           pre_ff;
   logic [LR-1:0]         clr_ff;

   logic                  accept;
   logic [NONCE_BITS-1:0] n_next;
   logic                  limit_hit;
   logic                  old_hit;
   logic                  advance;
   logic [NONCE_BITS-1:0] age;
   logic                  clr_done;

   logic [LR-1:0]         slot;
   logic [LW-1:0]         bit_idx;
   logic [TAG_BITS-1:0]   epoch;
   logic                  slot_ahead;
   logic                  tag_live;
   logic [WORD_BITS-1:0]  word_live;
   logic [WORD_BITS-1:0]  bit_mask;
   logic                  dup;
   verdict_type           verdict;

   assign accept = req_tvalid && req_tready;
   assign n_next = req_tdata + {{(NONCE_BITS-1){1'b0}}, 1'b1};
   assign clr_done = (clr_ff == LR'(RING_WORDS - 1));

   // check stage
   assign age       = highest_ff - n_ff;
   assign limit_hit = (highest_ff > limit) || (nonce_ff >= limit);
   assign old_hit   = (highest_ff > n_ff) && (age > NONCE_BITS'(WINDOW_SIZE));
   assign advance   = n_ff > highest_ff;

   // update stage: a word is live only if written since the window last
   // swept over its slot, i.e. its tag matches the current epoch of that slot
   assign slot       = n_ff[LW+LR-1:LW];
   assign bit_idx    = n_ff[LW-1:0];
   assign slot_ahead = slot > highest_ff[LW+LR-1:LW];
   assign epoch      = highest_ff[NONCE_BITS-1:LW+LR]
                       - {{(TAG_BITS-1){1'b0}}, slot_ahead};
   assign tag_live   = (mem_rdata[MEM_BITS-1:WORD_BITS] == epoch);
   assign word_live  = tag_live ? mem_rdata[WORD_BITS-1:0] : '0;
   assign bit_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_idx;
   assign dup        = |(word_live & bit_mask);
   assign verdict    = (pre_ff != V_OK) ? pre_ff : (dup ? V_DUP : V_OK);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_tready   = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = n_next[LW+LR-1:LW];
      mem_we       = 1'b0;
      mem_waddr    = slot;
      mem_wdata    = {epoch, word_live | bit_mask};
      resp.load    = 1'b0;
      resp.verdict = verdict;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            mem_re     = req_tvalid;
         end
         S_CHECK: begin
         end
         S_UPDATE: begin
            resp.load = out_free;
            mem_we    = out_free && (verdict == V_OK);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         highest_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + LR'(1);
         end
         if (state_ff == S_CHECK && !limit_hit && !old_hit && advance) begin
            highest_ff <= n_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         nonce_ff <= req_tdata;
         n_ff     <= n_next;
      end
      if (state_ff == S_CHECK) begin
         pre_ff <= limit_hit ? V_LIMIT : (old_hit ? V_OLD : V_OK);
      end
   end

endmodule

### src/anti_replay_window_check.sv
// Timing: check state, then update state (held while a response stalls), then
//    the result register. Flow: one nonce at a time, the check stage followed
//    by the read-modify-write of the ring word via the single memory read port.
// Reset: synchronous; the ring memory is cleared one word per cycle, all
//    TOTAL_BITS/WORD_BITS words, with req_tready low; csr writes still taken.
// TOTAL_BITS and WORD_BITS must be powers of two; the block does not enforce it.
// ----------------------------------------------------------------------------
// anti_replay_window_check
// Ring-bitmap anti-replay window with limit check and registered response.
// ----------------------------------------------------------------------------
module anti_replay_window_check
   import arw_pkg::*;
#(
   parameter int unsigned TOTAL_BITS  = 2048,
   parameter int unsigned WORD_BITS   = 64,
   parameter int unsigned WINDOW_SIZE = 1984
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] nonce
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] accepted, [2:1] verdict, [7:3] zero
   input  logic        csr_we,
   input  logic [63:0] csr_wdata    // reject_limit
);

   localparam int unsigned RING_WORDS = TOTAL_BITS / WORD_BITS;
   localparam int unsigned LR = $clog2(RING_WORDS);
   localparam int unsigned MEM_BITS = WORD_BITS + NONCE_BITS - $clog2(WORD_BITS) - LR;

   logic [NONCE_BITS-1:0] limit_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_data_ff;
   logic                  out_free;
   resp_type              resp;

   logic                  mem_we;
   logic [LR-1:0]         mem_waddr;
   logic [MEM_BITS-1:0]   mem_wdata;
   logic                  mem_re;
   logic [LR-1:0]         mem_raddr;
   logic [MEM_BITS-1:0]   mem_rdata;

   assign out_free = !rsp_valid_ff || rsp_tready;

   arw_ctrl #(
      .WORD_BITS   (WORD_BITS),
      .RING_WORDS  (RING_WORDS),
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .limit      (limit_ff),
      .out_free   (out_free),
      .resp       (resp),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   arw_ring_mem #(
      .DEPTH (RING_WORDS),
      .WIDTH (MEM_BITS)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (resp.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (resp.load) begin
         rsp_data_ff <= {5'd0, resp.verdict, resp.verdict == V_OK};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### src/arw_checker.sv
// ----------------------------------------------------------------------------
// arw_checker
// Port-level checks for the anti-replay window checker, bound to the top.
// ----------------------------------------------------------------------------
module arw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        csr_we,
   input logic [63:0] csr_wdata
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // accepted flag agrees with the verdict code
   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[2:1] == 2'd0)))
      else $error("accepted flag does not match verdict");

   // one nonce in flight: no transaction directly after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous nonce in flight");

   // ring clear follows reset: no request taken, no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block active right after reset");

endmodule

bind anti_replay_window_check arw_checker u_arw_checker (.*);

### tb/sv/arw_window_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arw_window_checker
// Watches the nonce and verdict streams of the anti-replay window checker,
// keeps its own copy of the ring bitmap, highest seen counter and limit, and
// compares every verdict transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module arw_window_checker
   import arw_pkg::*;
#(
   parameter int unsigned TOTAL_BITS  = 2048,
   parameter int unsigned WORD_BITS   = 64,
   parameter int unsigned WINDOW_SIZE = 1984
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,    // [63:0] nonce
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,    // [0] accepted, [2:1] verdict, [7:3] zero
   input  logic        csr_we,
   input  logic [63:0] csr_wdata,    // reject_limit
   output int          fail_count,
   output int          pending,
   output logic [63:0] window_front  // predicted highest seen (nonce + 1)
);

   localparam int unsigned RING_WORDS = TOTAL_BITS / WORD_BITS;

   typedef struct {
      logic [63:0] nonce;
      verdict_type verdict;
   } nonce_verdict_type;

   logic [63:0]          limit_model;
   logic [63:0]          highest_model;
   logic [WORD_BITS-1:0] seen_words [RING_WORDS];
   nonce_verdict_type    verdict_queue [$];
   int                   errors = 0;

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t ns: verdict mismatch: %s", $time, what);
   endtask

   // limit first, then window age, then the duplicate bit
   function automatic verdict_type classify_nonce(input logic [63:0] nonce);
      logic [63:0] n;
      logic [63:0] word_new;
      logic [63:0] word_cur;
      logic [63:0] span;
      logic [63:0] k;
      int unsigned slot;
      int unsigned pos;
      if (highest_model > limit_model || nonce >= limit_model) return V_LIMIT;
      n = nonce + 64'd1;
      if (highest_model > n && (highest_model - n) > 64'(WINDOW_SIZE)) return V_OLD;
      word_new = n / 64'(WORD_BITS);
      if (n > highest_model) begin
         // clear the words the window slides over, never more than the ring
         word_cur = highest_model / 64'(WORD_BITS);
         span = word_new - word_cur;
         if (span > 64'(RING_WORDS)) span = 64'(RING_WORDS);
         for (k = 64'd1; k <= span; k++)
            seen_words[32'((word_cur + k) % 64'(RING_WORDS))] = '0;
         highest_model = n;
      end
      slot = 32'(word_new % 64'(RING_WORDS));
      pos = 32'(n % 64'(WORD_BITS));
      if (seen_words[slot][pos]) return V_DUP;
      seen_words[slot][pos] = 1'b1;
      return V_OK;
   endfunction

   always @(posedge clock) begin
      nonce_verdict_type head;
      if (reset) begin
         limit_model = LIMIT_RESET;
         highest_model = '0;
         foreach (seen_words[i]) seen_words[i] = '0;
         verdict_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch($sformatf("result 0x%02h with none expected", rsp_tdata));
            end else begin
               head = verdict_queue.pop_front();
               if (rsp_tdata[0] !== (head.verdict == V_OK))
                  report_mismatch($sformatf("nonce %0d accepted %b, expected %b",
                     head.nonce, rsp_tdata[0], head.verdict == V_OK));
               if (rsp_tdata[2:1] !== head.verdict)
                  report_mismatch($sformatf("nonce %0d verdict %0d, expected %s",
                     head.nonce, rsp_tdata[2:1], head.verdict.name()));
               if (rsp_tdata[7:3] !== 5'd0)
                  report_mismatch($sformatf("nonce %0d padding bits 0x%02h",
                     head.nonce, rsp_tdata[7:3]));
            end
         end
         if (req_tvalid && req_tready) begin
            head.nonce = req_tdata;
            head.verdict = classify_nonce(req_tdata);
            verdict_queue.push_back(head);
         end
         if (csr_we) limit_model = csr_wdata;
      end
      pending <= verdict_queue.size();
      window_front <= highest_model;
      fail_count <= errors;
   end

endmodule

### tb/sv/tb_anti_replay_window_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_anti_replay_window_check
// Drives nonce transactions and limit writes into the anti-replay window
// checker: directed corner cases at the window edge, word boundaries, full
// ring clears and the limit, then random nonces clustered around the window
// front under several limit settings, with random back-pressure.
// ----------------------------------------------------------------------------
module tb_anti_replay_window_check;
   import arw_pkg::*;

   localparam int unsigned TOTAL_BITS  = 2048;
   localparam int unsigned WORD_BITS   = 64;
   localparam int unsigned WINDOW_SIZE = 1984;
   localparam int          CYCLE_LIMIT = 200000;
   localparam logic [63:0] ALL_ONES    = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we = 1'b0;
   logic [63:0] csr_wdata = '0;

   int          fail_count;
   int          pending;
   logic [63:0] window_front;
   logic [63:0] limit_now = LIMIT_RESET;
   bit          calm = 1'b0;
   bit          hold_rsp = 1'b0;
   int          cycles = 0;

   always #5 clock = ~clock;

   anti_replay_window_check #(
      .TOTAL_BITS (TOTAL_BITS),
      .WORD_BITS  (WORD_BITS),
      .WINDOW_SIZE(WINDOW_SIZE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   arw_window_checker #(
      .TOTAL_BITS (TOTAL_BITS),
      .WORD_BITS  (WORD_BITS),
      .WINDOW_SIZE(WINDOW_SIZE)
   ) chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .window_front(window_front)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_anti_replay_window_check failed");
         $finish;
      end
   end

   // verdict sink: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= 6);
         end
      end
   end

   task automatic send_nonce(input logic [63:0] value);
      if (!calm && $urandom_range(99, 0) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait until every verdict is back
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_limit(input logic [63:0] value);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_now = value;
   endtask

   // mostly inside or just behind the window, some advances, some noise
   function automatic logic [63:0] pick_nonce();
      int unsigned roll;
      logic [63:0] back;
      logic [63:0] base;
      base = window_front;
      roll = $urandom_range(99, 0);
      if (roll < 58) begin
         back = 64'($urandom_range(2100, 0));
         if (base > back) return base - 64'd1 - back;
         return 64'($urandom_range(63, 0));
      end
      if (roll < 80) return base + 64'($urandom_range(199, 0)) - 64'd1;
      if (roll < 88) return base + 64'($urandom_range(5000, 1000));
      if (roll < 92) return base + 64'($urandom_range(100000, 2048));
      if (roll < 96) return limit_now - 64'($urandom_range(3, 0));
      return {$urandom, $urandom};
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) send_nonce(pick_nonce());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // fresh, duplicate, word boundary, window slide and its exact edge
      send_nonce(64'd0);
      send_nonce(64'd0);
      send_nonce(64'd1);
      send_nonce(64'd63);
      send_nonce(64'd64);
      send_nonce(64'd2000);
      send_nonce(64'd0);
      send_nonce(64'd16);
      send_nonce(64'd15);
      send_nonce(64'd1999);
      send_nonce(64'd2000);
      // jump far enough to clear the whole ring
      send_nonce(64'd1000000);
      send_nonce(64'd999999);
      send_nonce(LIMIT_RESET);
      send_nonce(ALL_ONES);
      set_limit(64'd0);
      send_nonce(64'd0);
      send_nonce(64'd1000001);

      set_limit(ALL_ONES);
      run_random(100);
      calm = 1'b1;
      run_random(250);
      calm = 1'b0;
      settle();
      run_random(50);

      settle();
      set_limit(window_front + 64'd3000);
      run_random(300);

      set_limit(64'd0);
      run_random(50);

      // stored counter already past the limit
      settle();
      set_limit(window_front - 64'd1);
      run_random(50);

      settle();
      set_limit(window_front + 64'($urandom_range(20000, 4000)));
      run_random(100);
      hold_rsp = 1'b1;
      run_random(550);

      // top of the counter range
      set_limit(LIMIT_RESET);
      send_nonce(LIMIT_RESET - 64'd1);
      send_nonce(LIMIT_RESET);
      send_nonce(LIMIT_RESET - 64'd2);
      send_nonce(LIMIT_RESET - 64'd1);
      set_limit(ALL_ONES);
      send_nonce(ALL_ONES - 64'd2);
      send_nonce(ALL_ONES - 64'd1);
      send_nonce(ALL_ONES - 64'd1);
      send_nonce(ALL_ONES);
      send_nonce(ALL_ONES - 64'd1985);
      send_nonce(ALL_ONES - 64'd1986);
      set_limit(ALL_ONES - 64'd1);
      send_nonce(ALL_ONES - 64'd3);
      set_limit(64'd0);
      send_nonce(64'd5);

      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_anti_replay_window_check passed");
      end else begin
         $display("tb_anti_replay_window_check failed");
      end
      $finish;
   end

endmodule

### anti_replay_window_check.f
src/arw_pkg.sv
src/arw_ring_mem.sv
src/arw_ctrl.sv
src/anti_replay_window_check.sv
src/arw_checker.sv
tb/sv/arw_window_checker.sv
tb/sv/tb_anti_replay_window_check.sv
